@@ rtl/core/pooled_doubly_linked_list_core_macros.svh @@
// Assertion macros shared by the pooled list core.
`ifndef POOLED_DOUBLY_LINKED_LIST_CORE_MACROS_SVH
`define POOLED_DOUBLY_LINKED_LIST_CORE_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define PDLL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define PDLL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ rtl/core/pdll_pkg.sv @@
// Package with shared codes and widths of the pooled list core.
`timescale 1ns / 1ps
package pdll_pkg;
  localparam int unsigned PoolSizeDefault = 64;
  localparam int unsigned ValueWidth = 32;

  localparam logic [2:0] OpAppend  = 3'd0;
  localparam logic [2:0] OpInsert  = 3'd1;
  localparam logic [2:0] OpDelete  = 3'd2;
  localparam logic [2:0] OpReverse = 3'd3;
  localparam logic [2:0] OpPrint   = 3'd4;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StFull     = 2'd1;
  localparam logic [1:0] StNotFound = 2'd2;
  localparam logic [1:0] StEmpty    = 2'd3;
endpackage

@@ rtl/core/pooled_doubly_linked_list_core.sv @@
// Top level of the pooled doubly linked list core with its sequencer.
// A full or empty status is reported without entering a working state. Append and
// insert link the new node, relink its neighbors and scan for the next free slot;
// insert and delete first search the list, and reverse walks it once.
// Print sends each element as its own result, the last with tlast set. One request
// is worked on at a time; tready returns once the final result enters the output register.
// Reset (rst_ni low, asynchronous) empties the list, sets the allocation pointer to
// slot one and clears all used bits.
`timescale 1ns / 1ps
module pooled_doubly_linked_list_core
  import pdll_pkg::*;
#(
  parameter int unsigned POOL_SIZE = PoolSizeDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: operation [2:0], value [34:3], anchor_value [66:35], zero pad
  input  logic [71:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: status [1:0], data [33:2], zero pad
  output logic [39:0] m_axis_tdata,
  // tlast: last result of the request
  output logic        m_axis_tlast
);
`include "pooled_doubly_linked_list_core_macros.svh"
  localparam int unsigned IW = $clog2(POOL_SIZE);
  localparam int unsigned CW = IW + 1;
  localparam logic [IW-1:0] NullIdx = '0;
  localparam logic [CW-1:0] Capacity = CW'(POOL_SIZE - 1);
  localparam logic [IW-1:0] LastIdx = IW'(POOL_SIZE - 1);

  typedef enum logic [3:0] {
    SIdle, SFind, SLink, SRelink, SScan, SDelete, SRev, SPrint
  } state_e;

  // Memories: value and link arrays. All three are read at the node that
  // cur_q will hold next, so the registered read data always belongs to cur_q.
  // Each array takes at most one write per cycle.
  logic [ValueWidth-1:0] val_mem [POOL_SIZE];
  logic [IW-1:0]         prv_mem [POOL_SIZE];
  logic [IW-1:0]         nxt_mem [POOL_SIZE];

  state_e          state_q, state_d;
  logic [2:0]      op_q, op_d;
  logic [31:0]     val_q, val_d, anc_q, anc_d;
  logic [IW-1:0]   head_q, head_d, tail_q, tail_d, alloc_q, alloc_d;
  logic [IW-1:0]   cur_q, cur_d, scan_q, scan_d, slot_q, slot_d;
  logic [CW-1:0]   cnt_q, cnt_d, steps_q, steps_d;
  logic [1:0]      st_q, st_d;
  logic            pend_q, pend_d, pend_last_q, pend_last_d, last_q, last_d;
  logic [31:0]     pend_data_q, pend_data_d;
  logic [POOL_SIZE-1:0] used_q, used_d;

  logic            val_we, prv_we, nxt_we;
  logic [IW-1:0]   val_wa, prv_wa, nxt_wa, prv_wd, nxt_wd;
  logic [31:0]     val_wd;
  logic [31:0]     cv_q;
  logic [IW-1:0]   cp_q, cn_q;

  logic            out_full, out_load;
  logic [39:0]     out_data;
  logic [31:0]     find_key;
  logic [IW-1:0]   scan_nx, link_nxt;

  assign scan_nx  = (scan_q == LastIdx) ? IW'(1) : scan_q + IW'(1);
  // Successor of the predecessor node; an empty list has none.
  assign link_nxt = (cur_q == NullIdx) ? NullIdx : cn_q;
  assign find_key = (op_q == OpInsert) ? anc_q : val_q;

  assign s_axis_tready = (state_q == SIdle) && !pend_q;
  assign out_load = pend_q && !out_full;
  assign out_data = {6'd0, pend_data_q, st_q};

  pdll_out_reg u_out (
    .clk_i, .rst_ni, .load_i(out_load), .data_i(out_data), .full_o(out_full),
    .tvalid_o(m_axis_tvalid), .tready_i(m_axis_tready), .tdata_o(m_axis_tdata)
  );
  assign m_axis_tlast = last_q;

  always_ff @(posedge clk_i) begin
    if (val_we) val_mem[val_wa] <= val_wd;
    if (prv_we) prv_mem[prv_wa] <= prv_wd;
    if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
    cv_q <= val_mem[cur_d];
    cp_q <= prv_mem[cur_d];
    cn_q <= nxt_mem[cur_d];
  end

  always_comb begin
    state_d = state_q; op_d = op_q; val_d = val_q; anc_d = anc_q;
    head_d = head_q; tail_d = tail_q; alloc_d = alloc_q; cur_d = cur_q;
    scan_d = scan_q; slot_d = slot_q; cnt_d = cnt_q; steps_d = steps_q;
    st_d = st_q; pend_d = pend_q; pend_last_d = pend_last_q;
    pend_data_d = pend_data_q; used_d = used_q;
    last_d = out_load ? pend_last_q : last_q;
    val_we = 1'b0; val_wa = NullIdx; val_wd = '0;
    prv_we = 1'b0; prv_wa = NullIdx; prv_wd = NullIdx;
    nxt_we = 1'b0; nxt_wa = NullIdx; nxt_wd = NullIdx;
    if (out_load) pend_d = 1'b0;
    case (state_q)
      SIdle: begin
        if (s_axis_tvalid && s_axis_tready) begin
          op_d = s_axis_tdata[2:0]; val_d = s_axis_tdata[34:3];
          anc_d = s_axis_tdata[66:35];
          cur_d = head_q; steps_d = '0;
          pend_data_d = '0; pend_last_d = 1'b1; st_d = StOk;
          case (s_axis_tdata[2:0])
            OpAppend: begin
              if (cnt_q >= Capacity) begin
                st_d = StFull; pend_d = 1'b1;
              end else begin
                state_d = SLink; cur_d = tail_q;
              end
            end
            OpInsert: begin
              // A full pool is reported before the anchor is searched.
              if (cnt_q >= Capacity) begin
                st_d = StFull; pend_d = 1'b1;
              end else begin
                state_d = SFind;
              end
            end
            OpDelete: begin
              if (head_q == NullIdx) begin
                st_d = StEmpty; pend_d = 1'b1;
              end else begin
                state_d = SFind;
              end
            end
            OpReverse: state_d = SRev;
            OpPrint: begin
              if (head_q == NullIdx) begin
                st_d = StEmpty; pend_d = 1'b1;
              end else begin
                state_d = SPrint;
              end
            end
            default: pend_d = 1'b1;
          endcase
        end
      end
      SFind: begin
        // One compare per cycle along the list.
        if (cur_q == NullIdx || steps_q == CW'(POOL_SIZE)) begin
          st_d = StNotFound; pend_d = 1'b1; state_d = SIdle;
        end else if (cv_q == find_key) begin
          state_d = (op_q == OpInsert) ? SLink : SDelete;
        end else begin
          cur_d = cn_q; steps_d = steps_q + CW'(1);
        end
      end
      SLink: begin
        // cur_q is the predecessor (tail for append), alloc_q the new slot.
        val_we = 1'b1; val_wa = alloc_q; val_wd = val_q;
        prv_we = 1'b1; prv_wa = alloc_q; prv_wd = cur_q;
        nxt_we = 1'b1; nxt_wa = alloc_q; nxt_wd = link_nxt;
        used_d[alloc_q] = 1'b1;
        cnt_d = cnt_q + CW'(1);
        if (cur_q == NullIdx) begin
          head_d = alloc_q; tail_d = alloc_q;
        end else if (link_nxt == NullIdx) begin
          tail_d = alloc_q;
        end
        slot_d = alloc_q; scan_d = alloc_q; steps_d = '0;
        state_d = SRelink;
      end
      SRelink: begin
        // Point the neighbors at the new node.
        if (cur_q != NullIdx) begin
          nxt_we = 1'b1; nxt_wa = cur_q; nxt_wd = slot_q;
        end
        if (link_nxt != NullIdx) begin
          prv_we = 1'b1; prv_wa = link_nxt; prv_wd = slot_q;
        end
        state_d = SScan;
      end
      SScan: begin
        // Circular free-slot search, one slot per cycle.
        if (steps_q == CW'(POOL_SIZE)) begin
          pend_d = 1'b1; state_d = SIdle;
        end else if (!used_q[scan_nx]) begin
          alloc_d = scan_nx; pend_d = 1'b1; state_d = SIdle;
        end else begin
          scan_d = scan_nx; steps_d = steps_q + CW'(1);
        end
      end
      SDelete: begin
        if (cp_q == NullIdx) begin
          head_d = cn_q;
        end else begin
          nxt_we = 1'b1; nxt_wa = cp_q; nxt_wd = cn_q;
        end
        if (cn_q == NullIdx) begin
          tail_d = cp_q;
        end else begin
          prv_we = 1'b1; prv_wa = cn_q; prv_wd = cp_q;
        end
        used_d[cur_q] = 1'b0;
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          head_d = NullIdx; tail_d = NullIdx;
        end
        // Leaving the full state hands the freed slot to the next allocation.
        if (cnt_q >= Capacity) alloc_d = cur_q;
        pend_d = 1'b1; state_d = SIdle;
      end
      SRev: begin
        if (cur_q == NullIdx || steps_q == CW'(POOL_SIZE)) begin
          head_d = tail_q; tail_d = head_q;
          pend_d = 1'b1; state_d = SIdle;
        end else begin
          nxt_we = 1'b1; nxt_wa = cur_q; nxt_wd = cp_q;
          prv_we = 1'b1; prv_wa = cur_q; prv_wd = cn_q;
          cur_d = cn_q; steps_d = steps_q + CW'(1);
        end
      end
      SPrint: begin
        if (!pend_q) begin
          pend_data_d = cv_q;
          pend_last_d = (cn_q == NullIdx) || (steps_q == CW'(POOL_SIZE - 1));
          pend_d = 1'b1;
          if ((cn_q == NullIdx) || (steps_q == CW'(POOL_SIZE - 1))) state_d = SIdle;
          cur_d = cn_q; steps_d = steps_q + CW'(1);
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; used_q <= '0; head_q <= NullIdx; tail_q <= NullIdx;
      cnt_q <= '0; alloc_q <= IW'(1); pend_q <= 1'b0;
      op_q <= '0; val_q <= '0; anc_q <= '0; cur_q <= '0; scan_q <= '0;
      slot_q <= '0; steps_q <= '0; st_q <= StOk; pend_last_q <= 1'b0;
      pend_data_q <= '0; last_q <= 1'b0;
    end else begin
      state_q <= state_d; used_q <= used_d; head_q <= head_d; tail_q <= tail_d;
      cnt_q <= cnt_d; alloc_q <= alloc_d; pend_q <= pend_d;
      op_q <= op_d; val_q <= val_d; anc_q <= anc_d; cur_q <= cur_d; scan_q <= scan_d;
      slot_q <= slot_d; steps_q <= steps_d; st_q <= st_d; pend_last_q <= pend_last_d;
      pend_data_q <= pend_data_d; last_q <= last_d;
    end
  end

  `PDLL_ASSERT_IMP(a_cnt_cap, clk_i, rst_ni, 1'b1, cnt_q <= Capacity)
  `PDLL_ASSERT_IMP(a_empty_head, clk_i, rst_ni, cnt_q == '0, head_q == NullIdx)
  `PDLL_ASSERT_IMP(a_busy_no_accept, clk_i, rst_ni, state_q != SIdle, !s_axis_tready)
  `PDLL_ASSERT_NEXT(a_link_relink, clk_i, rst_ni, state_q == SLink, state_q == SRelink)
endmodule

@@ rtl/core/pdll_out_reg.sv @@
// Output register stage holding one result request.
`timescale 1ns / 1ps
module pdll_out_reg
  import pdll_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  logic [39:0] data_i,
  output logic        full_o,
  output logic        tvalid_o,
  input  logic        tready_i,
  output logic [39:0] tdata_o
);
  logic        valid_q;
  logic [39:0] data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (tready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign full_o   = valid_q;
  assign tvalid_o = valid_q;
  assign tdata_o  = data_q;
endmodule
